@@ rtl/srft_pkg.sv @@
// ---------------------------------------------------------------------------
// srft_pkg
// Shared types and constants of the sequential ratio fairness test.
// ---------------------------------------------------------------------------
`default_nettype none

package srft_pkg;

  localparam int QW = 48;
  typedef logic [QW-1:0] q_t;

  localparam q_t Q_ONE   = 48'h0001_0000_0000;
  localparam q_t Q_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam q_t Q_32    = 48'h0020_0000_0000;
  localparam q_t Q_48    = 48'h0030_0000_0000;
  // 1/log2(1.1), ln2/1.8 and 0.6*ln2 in Q.32
  localparam q_t K_INV_LOG2_1P1 = 48'd31235325313;
  localparam q_t K_LN2_DIV_1P8  = 48'd1653913595;
  localparam q_t K_06_LN2       = 48'd1786226683;

  localparam int DEF_COUNT_BITS = 24;
  localparam int SAMPLES_W      = 24;

  localparam int SLACK_W = 17;
  localparam int TOL_W   = 18;
  localparam int DELTA_W = 48;
  localparam int LIMIT_W = 24;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [SLACK_W-1:0] SLACK_RST = 17'd9830;
  localparam logic [TOL_W-1:0]   TOL_RST   = 18'd0;
  localparam logic [DELTA_W-1:0] DELTA_RST = 48'd14073;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd10000000;

  typedef enum logic [1:0] {
    REG_SLACK,
    REG_TOL,
    REG_DELTA,
    REG_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [SLACK_W-1:0] ratio_slack;
    logic [TOL_W-1:0]   tolerance;
    logic [DELTA_W-1:0] error_probability;
    logic [LIMIT_W-1:0] sample_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    VERDICT_KEEP,
    VERDICT_UNFAIR,
    VERDICT_FAIR,
    VERDICT_LIMIT
  } verdict_t;

  typedef enum logic [3:0] {
    OP_LG_N,
    OP_MUL_R,
    OP_LG_R,
    OP_MUL_T,
    OP_LG_D,
    OP_LG_24,
    OP_MUL_B,
    OP_DIV_Q,
    OP_SQRT,
    OP_DIV_EA,
    OP_DIV_EB,
    OP_DIV_RATIO,
    OP_DIV_E1,
    OP_DIV_E2,
    OP_MUL_ERR
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DECIDE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic start;
    op_t  op;
    logic decide;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic eb_gt_eps;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/srft_cfg.sv @@
// ---------------------------------------------------------------------------
// srft_cfg
// APB-style register file: slack, tolerance, error probability, limit.
// ---------------------------------------------------------------------------
`default_nettype none

module srft_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srft_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [srft_pkg::PDATA_W-1:0]  pwdata,
  output logic      [srft_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output srft_pkg::cfg_t                     cfg
);
  import srft_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_SLACK: cfg_nxt.ratio_slack       = pwdata[SLACK_W-1:0];
        REG_TOL:   cfg_nxt.tolerance         = pwdata[TOL_W-1:0];
        REG_DELTA: cfg_nxt.error_probability = pwdata[DELTA_W-1:0];
        REG_LIMIT: cfg_nxt.sample_limit      = pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLACK: prdata = PDATA_W'(cfg_r.ratio_slack);
      REG_TOL:   prdata = PDATA_W'(cfg_r.tolerance);
      REG_DELTA: prdata = PDATA_W'(cfg_r.error_probability);
      REG_LIMIT: prdata = PDATA_W'(cfg_r.sample_limit);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_slack       <= SLACK_RST;
      cfg_r.tolerance         <= TOL_RST;
      cfg_r.error_probability <= DELTA_RST;
      cfg_r.sample_limit      <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/srft_datapath.sv @@
// ---------------------------------------------------------------------------
// srft_datapath
// Counters, shared arithmetic engine (log2, multiply, divide, square root)
// and the verdict logic.
// ---------------------------------------------------------------------------
`default_nettype none

module srft_datapath #(
  parameter int COUNT_BITS = srft_pkg::DEF_COUNT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srft_pkg::dp_cmd_t               cmd,
  output srft_pkg::dp_status_t                 status,
  input  wire srft_pkg::cfg_t                  cfg,
  input  wire logic                            in_outcome_a,
  input  wire logic                            in_outcome_b,
  output logic [1:0]                           out_verdict,
  output logic [srft_pkg::SAMPLES_W-1:0]       out_samples_taken
);
  import srft_pkg::*;

  localparam int CMPW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  typedef enum logic [1:0] {K_LOG, K_MUL, K_DIV, K_SQRT} unit_t;

  // run counters
  logic [COUNT_BITS-1:0] pair_count_r, pair_count_nxt;
  logic [COUNT_BITS-1:0] sum_a_r, sum_a_nxt;
  logic [COUNT_BITS-1:0] sum_b_r, sum_b_nxt;

  // intermediate results
  q_t lg_n_r, r_r, lg_r_r, t_r, lg_d_r, lg_24_r, b_r, q_r;
  q_t eps_r, ea_r, eb_r, ratio_r, e1_r, e2_r, err_r;

  verdict_t verdict_r, verdict_nxt;
  verdict_t out_verdict_r;
  logic [SAMPLES_W-1:0] out_samples_r;

  // engine control
  logic  busy_r, busy_nxt;
  logic  done_r, done_nxt;
  unit_t unit_r, unit_nxt;
  op_t   cur_op_r, cur_op_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // log unit
  logic        lphase_r, lphase_nxt;
  logic [47:0] w_r, w_nxt;
  logic [5:0]  p_r, p_nxt;
  logic [31:0] m_r, m_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [32:0] sq;

  // multiply unit
  logic [46:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [93:0] acc_r, acc_nxt, acc_add;
  logic [47:0] prod_r, prod_nxt;
  logic [1:0]  pshift_r, pshift_nxt, pshift_sel;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  // divide unit
  logic [47:0] rem_r, rem_nxt, dlow_r, dlow_nxt, quo_r, quo_nxt, dv_r, dv_nxt;
  logic        dsat_r, dsat_nxt;
  logic [48:0] rem_sh;
  logic        dge;

  // square root unit
  logic [63:0] sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt, st;

  logic  fin;
  q_t    res_val;
  q_t    opa, opb;
  unit_t op_unit;
  logic  int_div;
  logic [48:0] err_sum;

  logic signed [51:0] fv, errs, tls, fair_m, unfair_m;
  logic [CMPW-1:0] cnt_cmp, lim_cmp;

  assign status.done      = done_r;
  assign status.eb_gt_eps = (eb_r > eps_r);

  // operand selection for a new operation
  always_comb begin
    opa     = '0;
    opb     = '0;
    op_unit = K_LOG;
    int_div = 1'b0;
    unique case (cmd.op)
      OP_LG_N:      opa = QW'(pair_count_r);
      OP_LG_R:      opa = r_r + Q_ONE;
      OP_LG_D:      opa = cfg.error_probability;
      OP_LG_24:     opa = 48'd24;
      OP_MUL_R: begin
        op_unit = K_MUL; opa = lg_n_r; opb = K_INV_LOG2_1P1;
      end
      OP_MUL_T: begin
        op_unit = K_MUL; opa = K_06_LN2; opb = lg_r_r - Q_32;
      end
      OP_MUL_B: begin
        op_unit = K_MUL; opa = lg_24_r + Q_48 - lg_d_r; opb = K_LN2_DIV_1P8;
      end
      OP_MUL_ERR: begin
        op_unit = K_MUL; opa = e1_r; opb = e2_r;
      end
      OP_DIV_Q: begin
        op_unit = K_DIV; int_div = 1'b1; opa = t_r + b_r; opb = QW'(pair_count_r);
      end
      OP_SQRT:      op_unit = K_SQRT;
      OP_DIV_EA: begin
        op_unit = K_DIV; opa = QW'(sum_a_r); opb = QW'(pair_count_r);
      end
      OP_DIV_EB: begin
        op_unit = K_DIV; opa = QW'(sum_b_r); opb = QW'(pair_count_r);
      end
      OP_DIV_RATIO: begin
        op_unit = K_DIV; opa = QW'(sum_a_r); opb = QW'(sum_b_r);
      end
      OP_DIV_E1: begin
        op_unit = K_DIV; opa = eps_r; opb = eb_r;
      end
      OP_DIV_E2: begin
        op_unit = K_DIV; opa = eps_r + ea_r; opb = eb_r - eps_r;
      end
      default: ;
    endcase
  end

  // shared multiplier: squaring for the log, 24-bit partial products otherwise
  always_comb begin
    mul_x      = m_r;
    mul_y      = m_r;
    pshift_sel = 2'd0;
    if (unit_r == K_MUL) begin
      unique case (cnt_r[1:0])
        2'd0: begin
          mul_x = 32'(ma_r[23:0]);  mul_y = 32'(mb_r[23:0]);  pshift_sel = 2'd0;
        end
        2'd1: begin
          mul_x = 32'(ma_r[23:0]);  mul_y = 32'(mb_r[46:24]); pshift_sel = 2'd1;
        end
        2'd2: begin
          mul_x = 32'(ma_r[46:24]); mul_y = 32'(mb_r[23:0]);  pshift_sel = 2'd1;
        end
        2'd3: begin
          mul_x = 32'(ma_r[46:24]); mul_y = 32'(mb_r[46:24]); pshift_sel = 2'd2;
        end
      endcase
    end
  end

  assign mul_p  = mul_x * mul_y;
  assign sq     = mul_p[63:31];
  assign rem_sh = {rem_r, dlow_r[47]};
  assign dge    = (rem_sh >= {1'b0, dv_r});
  assign st     = sres_r + sbit_r;

  always_comb begin
    unique case (pshift_r)
      2'd0:    acc_add = 94'(prod_r);
      2'd1:    acc_add = 94'(prod_r) << 24;
      2'd2:    acc_add = 94'(prod_r) << 48;
      default: acc_add = '0;
    endcase
  end

  // engine sequencing
  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    unit_nxt   = unit_r;
    cur_op_nxt = cur_op_r;
    cnt_nxt    = cnt_r;
    lphase_nxt = lphase_r;
    w_nxt      = w_r;
    p_nxt      = p_r;
    m_nxt      = m_r;
    frac_nxt   = frac_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    acc_nxt    = acc_r;
    prod_nxt   = prod_r;
    pshift_nxt = pshift_r;
    rem_nxt    = rem_r;
    dlow_nxt   = dlow_r;
    quo_nxt    = quo_r;
    dv_nxt     = dv_r;
    dsat_nxt   = dsat_r;
    sv_nxt     = sv_r;
    sres_nxt   = sres_r;
    sbit_nxt   = sbit_r;
    fin        = 1'b0;
    res_val    = '0;

    if (cmd.start) begin
      busy_nxt   = 1'b1;
      unit_nxt   = op_unit;
      cur_op_nxt = cmd.op;
      unique case (op_unit)
        K_LOG: begin
          w_nxt      = (opa == '0) ? 48'd1 : opa;
          p_nxt      = 6'd47;
          lphase_nxt = 1'b0;
          frac_nxt   = '0;
        end
        K_MUL: begin
          ma_nxt  = (opa > Q_MAX) ? Q_MAX[46:0] : opa[46:0];
          mb_nxt  = (opb > Q_MAX) ? Q_MAX[46:0] : opb[46:0];
          acc_nxt = '0;
          cnt_nxt = 6'd0;
        end
        K_DIV: begin
          dv_nxt  = opb;
          cnt_nxt = 6'd47;
          quo_nxt = '0;
          if (int_div) begin
            rem_nxt  = '0;
            dlow_nxt = opa;
            dsat_nxt = (opb == '0);
          end else begin
            rem_nxt  = 48'(opa[47:16]);
            dlow_nxt = {opa[15:0], 32'd0};
            dsat_nxt = (opb == '0) || ({15'd0, opa} >= {opb, 15'd0});
          end
        end
        K_SQRT: begin
          sv_nxt   = {q_r[37:0], 26'd0};
          sres_nxt = '0;
          sbit_nxt = 64'h4000_0000_0000_0000;
          cnt_nxt  = 6'd31;
        end
      endcase
    end else if (busy_r) begin
      unique case (unit_r)
        K_LOG: begin
          if (!lphase_r) begin
            if (w_r[47]) begin
              lphase_nxt = 1'b1;
              m_nxt      = w_r[47:16];
              cnt_nxt    = 6'd31;
            end else begin
              w_nxt = w_r << 1;
              p_nxt = p_r - 6'd1;
            end
          end else begin
            m_nxt    = sq[32] ? sq[32:1] : sq[31:0];
            frac_nxt = {frac_r[30:0], sq[32]};
            cnt_nxt  = cnt_r - 6'd1;
            if (cnt_r == 6'd0) begin
              fin     = 1'b1;
              res_val = {10'd0, p_r, frac_nxt};
            end
          end
        end
        K_MUL: begin
          if (cnt_r != 6'd4) begin
            prod_nxt   = mul_p[47:0];
            pshift_nxt = pshift_sel;
          end
          if (cnt_r != 6'd0) acc_nxt = acc_r + acc_add;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd4) begin
            fin     = 1'b1;
            res_val = (acc_nxt[93:79] != '0) ? Q_MAX : {1'b0, acc_nxt[78:32]};
          end
        end
        K_DIV: begin
          if (dsat_r) begin
            fin     = 1'b1;
            res_val = Q_MAX;
          end else begin
            rem_nxt  = dge ? 48'(rem_sh - {1'b0, dv_r}) : rem_sh[47:0];
            dlow_nxt = dlow_r << 1;
            quo_nxt  = {quo_r[46:0], dge};
            cnt_nxt  = cnt_r - 6'd1;
            if (cnt_r == 6'd0) begin
              fin     = 1'b1;
              res_val = quo_nxt;
            end
          end
        end
        K_SQRT: begin
          if (sv_r >= st) begin
            sv_nxt   = sv_r - st;
            sres_nxt = (sres_r >> 1) + sbit_r;
          end else begin
            sres_nxt = sres_r >> 1;
          end
          sbit_nxt = sbit_r >> 2;
          cnt_nxt  = cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            fin     = 1'b1;
            res_val = {sres_nxt[44:0], 3'd0};
          end
        end
      endcase
      if (fin) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign err_sum = {1'b0, e1_r} + {1'b0, res_val};

  // verdict
  assign fv       = $signed({4'd0, ratio_r}) - $signed({4'd0, Q_ONE})
                  + $signed({19'd0, cfg.ratio_slack, 16'd0});
  assign errs     = $signed({4'd0, err_r});
  assign tls      = $signed({{18{cfg.tolerance[TOL_W-1]}}, cfg.tolerance, 16'd0});
  assign fair_m   = fv - errs + tls;
  assign unfair_m = fv + errs - tls;
  assign cnt_cmp  = CMPW'(pair_count_r);
  assign lim_cmp  = CMPW'(cfg.sample_limit);

  always_comb begin
    verdict_nxt = verdict_r;
    if (cmd.decide) begin
      verdict_nxt = VERDICT_KEEP;
      if (status.eb_gt_eps) begin
        if (fair_m >= 0)        verdict_nxt = VERDICT_FAIR;
        else if (unfair_m <= 0) verdict_nxt = VERDICT_UNFAIR;
      end
      // limit 0 behaves as 1, which the count always meets
      if (verdict_nxt == VERDICT_KEEP && ((cnt_cmp >= lim_cmp) || (&pair_count_r)))
        verdict_nxt = VERDICT_LIMIT;
    end
  end

  // counters
  always_comb begin
    pair_count_nxt = pair_count_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    if (cmd.accept) begin
      if (!(&pair_count_r))           pair_count_nxt = pair_count_r + 1'b1;
      if (in_outcome_a && !(&sum_a_r)) sum_a_nxt     = sum_a_r + 1'b1;
      if (in_outcome_b && !(&sum_b_r)) sum_b_nxt     = sum_b_r + 1'b1;
    end else if (cmd.finish && verdict_r != VERDICT_KEEP) begin
      pair_count_nxt = '0;
      sum_a_nxt      = '0;
      sum_b_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r <= '0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      busy_r       <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      pair_count_r <= pair_count_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      busy_r       <= busy_nxt;
      done_r       <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r    <= unit_nxt;
    cur_op_r  <= cur_op_nxt;
    cnt_r     <= cnt_nxt;
    lphase_r  <= lphase_nxt;
    w_r       <= w_nxt;
    p_r       <= p_nxt;
    m_r       <= m_nxt;
    frac_r    <= frac_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    pshift_r  <= pshift_nxt;
    rem_r     <= rem_nxt;
    dlow_r    <= dlow_nxt;
    quo_r     <= quo_nxt;
    dv_r      <= dv_nxt;
    dsat_r    <= dsat_nxt;
    sv_r      <= sv_nxt;
    sres_r    <= sres_nxt;
    sbit_r    <= sbit_nxt;
    verdict_r <= verdict_nxt;
    if (cmd.finish) begin
      out_verdict_r <= verdict_r;
      out_samples_r <= SAMPLES_W'(pair_count_r);
    end
    if (fin) begin
      unique case (cur_op_r)
        OP_LG_N:      lg_n_r  <= res_val;
        OP_MUL_R:     r_r     <= res_val;
        OP_LG_R:      lg_r_r  <= res_val;
        OP_MUL_T:     t_r     <= res_val;
        OP_LG_D:      lg_d_r  <= res_val;
        OP_LG_24:     lg_24_r <= res_val;
        OP_MUL_B:     b_r     <= res_val;
        OP_DIV_Q:     q_r     <= res_val;
        OP_SQRT:      eps_r   <= res_val;
        OP_DIV_EA:    ea_r    <= res_val;
        OP_DIV_EB:    eb_r    <= res_val;
        OP_DIV_RATIO: ratio_r <= res_val;
        OP_DIV_E1:    e1_r    <= res_val;
        OP_DIV_E2:    e2_r    <= res_val;
        OP_MUL_ERR:   err_r   <= (err_sum > {1'b0, Q_MAX}) ? Q_MAX : err_sum[47:0];
        default: ;
      endcase
    end
  end

  assign out_verdict       = out_verdict_r;
  assign out_samples_taken = out_samples_r;

endmodule

`default_nettype wire

@@ rtl/srft_ctrl.sv @@
// ---------------------------------------------------------------------------
// srft_ctrl
// Sequencer: steps the datapath through the bound, means and ratio test
// for each item and hands the verdict to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module srft_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output srft_pkg::dp_cmd_t         cmd,
  input  wire srft_pkg::dp_status_t status
);
  import srft_pkg::*;

  ctrl_state_t state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic        out_valid_r, out_valid_nxt;
  op_t         op_follow;

  always_comb begin
    unique case (op_r)
      OP_LG_N:      op_follow = OP_MUL_R;
      OP_MUL_R:     op_follow = OP_LG_R;
      OP_LG_R:      op_follow = OP_MUL_T;
      OP_MUL_T:     op_follow = OP_LG_D;
      OP_LG_D:      op_follow = OP_LG_24;
      OP_LG_24:     op_follow = OP_MUL_B;
      OP_MUL_B:     op_follow = OP_DIV_Q;
      OP_DIV_Q:     op_follow = OP_SQRT;
      OP_SQRT:      op_follow = OP_DIV_EA;
      OP_DIV_EA:    op_follow = OP_DIV_EB;
      OP_DIV_EB:    op_follow = OP_DIV_RATIO;
      OP_DIV_RATIO: op_follow = OP_DIV_E1;
      OP_DIV_E1:    op_follow = OP_DIV_E2;
      OP_DIV_E2:    op_follow = OP_MUL_ERR;
      default:      op_follow = OP_LG_N;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = op_r;
    cmd.decide = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_nxt     = OP_LG_N;
          state_nxt  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.done) begin
          // mean of B inside the bound: no ratio test needed
          if (op_r == OP_MUL_ERR || (op_r == OP_DIV_EB && !status.eb_gt_eps)) begin
            state_nxt = ST_DECIDE;
          end else begin
            op_nxt    = op_follow;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_LG_N;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sequential_ratio_fairness_test_top.sv @@
// ---------------------------------------------------------------------------
// sequential_ratio_fairness_test_top
// Sequential ratio fairness test with an adaptive concentration bound.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  in       | in_valid / in_ready   | in_outcome_a, in_outcome_b
//  out      | out_valid / out_ready | out_verdict, out_samples_taken
//  cfg      | psel penable pwrite   | paddr (8 bytes a register), pwdata
//
// One item at a time. On the shared unit, log2 normalises by shifts, then
// squares once per fraction bit; multiply sums four partial products; division
// and square root yield one result bit per step, division ending at once when
// it saturates. A full item runs four logs, four multiplies, six divisions and
// the square root, plus accept, decide and finish steps; items whose B mean
// lies inside the bound skip three divisions and a multiply. The next item is
// taken while a verdict waits in the output register, but finish stalls until
// that verdict is read. Synchronous active-low reset.
// ---------------------------------------------------------------------------
`default_nettype none

module sequential_ratio_fairness_test_top #(
  parameter int COUNT_BITS = srft_pkg::DEF_COUNT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_outcome_a,
  input  wire logic                          in_outcome_b,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_verdict,
  output logic [srft_pkg::SAMPLES_W-1:0]     out_samples_taken,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srft_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [srft_pkg::PDATA_W-1:0]  pwdata,
  output logic      [srft_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import srft_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  srft_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  srft_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg),
    .in_outcome_a      (in_outcome_a),
    .in_outcome_b      (in_outcome_b),
    .out_verdict       (out_verdict),
    .out_samples_taken (out_samples_taken)
  );

endmodule

`default_nettype wire

@@ dv/sequential_ratio_fairness_test_top_test.sv @@
// ---------------------------------------------------------------------------
// sequential_ratio_fairness_test_top_test
// Checks each verdict and sample count of the fairness test against a
// bit-exact fixed-point predictor. Outcome pairs go in over a valid/ready
// channel, registers are set over the APB port between phases, and both
// channels idle in random bursts.
// ---------------------------------------------------------------------------
`default_nettype none

module sequential_ratio_fairness_test_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srft_pkg::*;

  typedef logic [63:0] u64_t;

  typedef struct {
    verdict_t verdict;
    logic [SAMPLES_W-1:0] samples;
  } verdict_rec_t;

  localparam u64_t ONE_Q  = 64'h1_0000_0000;
  localparam u64_t MAX_Q  = (64'd1 << 47) - 1;
  localparam u64_t CNT_MAX = (64'd1 << DEF_COUNT_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_outcome_a = 1'b0;
  logic in_outcome_b = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic [SAMPLES_W-1:0] out_samples_taken;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor copy of registers and counters
  logic [SLACK_W-1:0] slack_reg = SLACK_RST;
  logic [TOL_W-1:0]   tol_reg   = TOL_RST;
  logic [DELTA_W-1:0] delta_reg = DELTA_RST;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RST;
  u64_t pairs = 0, hits_a = 0, hits_b = 0;

  verdict_rec_t pending_verdicts[$];
  int mismatches = 0;
  bit calm = 1'b0;
  int ready_hold = 0;

  sequential_ratio_fairness_test_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_outcome_a(in_outcome_a), .in_outcome_b(in_outcome_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_verdict(out_verdict), .out_samples_taken(out_samples_taken),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30ms;
    $display("sequential_ratio_fairness_test_top: mismatch");
    $finish;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic u64_t log2_q(u64_t v);
    int p;
    u64_t m, frac;
    frac = 0;
    if (v == 0) v = 1;
    p = 63;
    while (p > 0 && !v[p]) p--;
    m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
    for (int k = 31; k >= 0; k--) begin
      m = (m * m) >> 31;
      if (m >= ONE_Q) begin
        m = m >> 1;
        frac[k] = 1'b1;
      end
    end
    return (u64_t'(p) << 32) | frac;
  endfunction

  function automatic u64_t mul_q(u64_t a, u64_t b);
    u64_t ah, al, bh, bl, r;
    if (a > MAX_Q) a = MAX_Q;
    if (b > MAX_Q) b = MAX_Q;
    ah = a >> 32; al = a & 64'hFFFF_FFFF;
    bh = b >> 32; bl = b & 64'hFFFF_FFFF;
    r = ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    return (r > MAX_Q) ? MAX_Q : r;
  endfunction

  function automatic u64_t div_q(u64_t a, u64_t b);
    u64_t whole, rem, frac;
    frac = 0;
    if (b == 0) return MAX_Q;
    whole = a / b;
    if (whole > (MAX_Q >> 32)) return MAX_Q;
    rem = a % b;
    for (int k = 31; k >= 0; k--) begin
      rem = rem << 1;
      if (rem >= b) begin
        rem = rem - b;
        frac[k] = 1'b1;
      end
    end
    whole = (whole << 32) | frac;
    return (whole > MAX_Q) ? MAX_Q : whole;
  endfunction

  function automatic u64_t sqrt_int(u64_t v);
    u64_t res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic u64_t hoeffding_bound(u64_t n);
    u64_t d, rr, tt, bn, bb, qq;
    d = u64_t'(delta_reg);
    if (d == 0) d = 1;
    rr = mul_q(log2_q(n), u64_t'(K_INV_LOG2_1P1));
    tt = mul_q(u64_t'(K_06_LN2), log2_q(rr + ONE_Q) - (64'd32 << 32));
    bn = log2_q(24) + (64'd48 << 32) - log2_q(d);
    bb = mul_q(bn, u64_t'(K_LN2_DIV_1P8));
    qq = (tt + bb) / n;
    return sqrt_int(qq << 26) << 3;
  endfunction

  function automatic verdict_rec_t judge_pair(logic a, logic b);
    verdict_rec_t rec;
    u64_t lim, n, eps, ma, mb, ratio, e1, e2, err;
    longint fv, tl;
    verdict_t v;
    v = VERDICT_KEEP;
    lim = u64_t'(limit_reg);
    if (lim == 0) lim = 1;
    n = (pairs < CNT_MAX) ? pairs + 1 : CNT_MAX;
    if (a && hits_a < CNT_MAX) hits_a++;
    if (b && hits_b < CNT_MAX) hits_b++;
    pairs = n;
    eps = hoeffding_bound(n);
    ma = div_q(hits_a, n);
    mb = div_q(hits_b, n);
    if (mb > eps) begin
      ratio = div_q(hits_a, hits_b);
      e1 = div_q(eps, mb);
      e2 = div_q(eps + ma, mb - eps);
      err = e1 + mul_q(e1, e2);
      if (err > MAX_Q) err = MAX_Q;
      fv = longint'(ratio) - longint'(ONE_Q) + longint'(u64_t'(slack_reg)) * 65536;
      tl = longint'($signed(tol_reg)) * 65536;
      if (fv - longint'(err) >= -tl) v = VERDICT_FAIR;
      else if (fv + longint'(err) <= tl) v = VERDICT_UNFAIR;
    end
    if (v == VERDICT_KEEP && (n >= lim || n >= CNT_MAX)) v = VERDICT_LIMIT;
    if (v != VERDICT_KEEP) begin
      pairs = 0; hits_a = 0; hits_b = 0;
    end
    rec.verdict = v;
    rec.samples = n[SAMPLES_W-1:0];
    return rec;
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what);
    $display("[%0t] verdict check: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want.verdict)
          report_mismatch($sformatf("verdict %0d, want %0d (n %0d)",
                          out_verdict, want.verdict, want.samples));
        if (out_samples_taken !== want.samples)
          report_mismatch($sformatf("samples %0d, want %0d",
                          out_samples_taken, want.samples));
      end
    end
  end

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(7) == 0) begin
      ready_hold <= $urandom_range(18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- driving ----------------
  task automatic write_reg(reg_idx_t idx, u64_t value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = PADDR_W'(8 * int'(idx));
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_SLACK: slack_reg = value[SLACK_W-1:0];
      REG_TOL:   tol_reg   = value[TOL_W-1:0];
      REG_DELTA: delta_reg = value[DELTA_W-1:0];
      REG_LIMIT: limit_reg = value[LIMIT_W-1:0];
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_config(u64_t slack, u64_t tol, u64_t delta, u64_t limit);
    wait (pending_verdicts.size() == 0);
    write_reg(REG_SLACK, slack);
    write_reg(REG_TOL, tol);
    write_reg(REG_DELTA, delta);
    write_reg(REG_LIMIT, limit);
  endtask

  task automatic send_pair(logic a, logic b);
    int gap;
    gap = (!calm && $urandom_range(5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_outcome_a = a;
    in_outcome_b = b;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(judge_pair(a, b));
    // drop valid so a waiting caller never offers the same item twice
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_run(int count, int pa, int pb);
    for (int i = 0; i < count; i++)
      send_pair($urandom_range(99) < pa, $urandom_range(99) < pb);
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_values();
    send_pair(1'b0, 1'b0);
    send_pair(1'b1, 1'b1);
    send_pair(1'b1, 1'b0);
    send_pair(1'b0, 1'b1);
  endtask

  task automatic test_tiny_limits();
    // zero limit acts as one, zero delta as one
    set_config(0, 0, 0, 0);
    send_pair(1'b1, 1'b1);
    send_pair(1'b0, 1'b0);
    set_config(9830, 0, 1, 1);
    send_pair(1'b0, 1'b1);
    set_config(65536, 18'h20000, 48'hFFFF_FFFF_FFFF, 3);
    repeat (6) send_pair(1'b1, 1'b1);
  endtask

  task automatic test_decisions();
    // loose bound: fair and unfair verdicts come quickly
    set_config(65536, 65536, 48'hFFFF_FFFF_FFFF, 50);
    send_run(8, 90, 90);
    set_config(0, 18'h30000, 48'hFFFF_FFFF_FFFF, 50);
    send_run(8, 10, 90);
    // slack above one
    set_config(17'h1FFFF, 0, 48'h8000_0000_0000, 40);
    send_run(6, 50, 80);
  endtask

  task automatic test_random_runs();
    u64_t tol;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 9) calm = 1'b1;
      tol = $urandom_range(131072);
      if ($urandom_range(1)) tol = (~tol + 1) & 64'h3FFFF;
      set_config($urandom_range(131071), tol,
                 {$urandom_range(65535), 32'($urandom)} | 48'h8000_0000_0000
                   >> $urandom_range(40),
                 $urandom_range(3) == 0 ? $urandom_range(16777215) : $urandom_range(1, 80));
      send_run(60, $urandom_range(100), $urandom_range(100));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_tiny_limits();
    test_decisions();
    test_random_runs();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("sequential_ratio_fairness_test_top: match");
    end else begin
      $display("sequential_ratio_fairness_test_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
